// ----- design/eert_pkg.sv -----
// ----------------------------------------------------------------------------
// Error event report table package
// Shared types and constants for the error event report table.
// ----------------------------------------------------------------------------
package eert_pkg;

   // Width of an error identifier, fixed by the payload formats.
   localparam int CODE_BITS    = 16;
   // Default table depth.
   localparam int ENTRIES_DEF  = 32;
   // Width of an entry's report counter and its saturation value.
   localparam int CNT_BITS     = 9;
   localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

   // Request type codes.
   localparam logic [1:0] REQ_RAISE = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Configuration register indexes.
   localparam logic REG_REPEAT_COUNT = 1'b0;
   localparam logic REG_TABLE_LIMIT  = 1'b1;

   // Configuration register reset values.
   localparam logic [7:0] REPEAT_RESET = 8'd3;
   localparam logic [4:0] LIMIT_RESET  = 5'd31;

   // Input beat.
   typedef struct packed {
      logic [1:0]           req_type;
      logic [CODE_BITS-1:0] fault_code;
   } req_item_type;

   // Result beat.
   typedef struct packed {
      logic [CODE_BITS-1:0] report_code;
      logic                 report_active;
      logic [7:0]           report_count;
      logic                 last;
   } rsp_item_type;

   // One table entry as stored in the RAM.
   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 active;
      logic [CNT_BITS-1:0]  count;
      logic                 reported;
      logic                 pending;
   } entry_type;

endpackage

// ----- design/error_event_report_table.sv -----
// ----------------------------------------------------------------------------
// Error event report table
// Insertion-ordered table of error codes with per-entry report state. Raise
// and clear beats update the table; tick beats report pending entries.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                 Payload
//   req_      in          req_valid / req_stall     req_item_type
//   rsp_      out         rsp_valid / rsp_stall     rsp_item_type
//   csr_      in/out      APB write, pready high    repeat_count, table_limit
//
// Each visited entry takes a read state and an evaluate state on the one
// RAM read port. A raise or clear searches from the oldest entry; a raise
// that misses evicts the oldest entry, shifting the rest down, when the
// table is full or over table_limit, then appends. A tick sweeps every
// entry and waits on result-side stalls; req_stall is high throughout.
// Reset is synchronous and leaves the table empty without a clearing pass.
// ----------------------------------------------------------------------------
module error_event_report_table
   import eert_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Input channel
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   // Result channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   // Configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int TOT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (TOT_W > 5) ? TOT_W : 5;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SRCH_RD  = 9'b000000010,
      S_SRCH_EV  = 9'b000000100,
      S_SHIFT_RD = 9'b000001000,
      S_SHIFT_EV = 9'b000010000,
      S_APPEND   = 9'b000100000,
      S_TICK_RD  = 9'b001000000,
      S_TICK_EV  = 9'b010000000,
      S_TICK_END = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 raise_ff, raise_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [TOT_W-1:0]     idx_ff, idx_in;
   logic [TOT_W-1:0]     wptr_ff, wptr_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   rsp_item_type         hold_ff, hold_in;
   logic                 hold_valid_ff, hold_valid_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           repeat_ff;
   logic [4:0]           limit_ff;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [$bits(entry_type)-1:0] ram_rdata;

   entry_type            entry;
   logic [CNT_BITS-1:0]  count_inc;
   logic [CNT_BITS-1:0]  repeat_ext;
   logic [TOT_W-1:0]     idx_dec;
   logic                 evict;
   logic                 out_free;
   logic                 csr_write;

   // Entry storage.
   eert_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Helpers on the entry just read.
   assign entry      = entry_type'(ram_rdata);
   assign count_inc  = (entry.count == COUNT_MAX) ? entry.count
                                                  : entry.count + CNT_BITS'(1);
   assign repeat_ext = CNT_BITS'(repeat_ff);
   assign idx_dec    = idx_ff - TOT_W'(1);
   assign evict      = (CMP_W'(total_ff) > CMP_W'(limit_ff)) ||
                       (total_ff >= TOT_W'(ENTRIES));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      raise_in      = raise_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      total_in      = total_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IDX_W-1:0];
      ram_wdata     = entry;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff[IDX_W-1:0];

      // The result register empties when its beat is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code_in = req_data.fault_code;
               idx_in  = '0;
               unique case (req_data.req_type)
                  REQ_RAISE: begin
                     raise_in = 1'b1;
                     state_in = S_SRCH_RD;
                  end
                  REQ_CLEAR: begin
                     raise_in = 1'b0;
                     state_in = S_SRCH_RD;
                  end
                  REQ_TICK: begin
                     wptr_in       = '0;
                     hold_valid_in = 1'b0;
                     state_in      = S_TICK_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Search for the code, one entry per read.
         S_SRCH_RD: begin
            if (idx_ff == total_ff) begin
               if (!raise_ff) begin
                  state_in = S_IDLE;
               end else if (evict) begin
                  idx_in   = TOT_W'(1);
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_APPEND;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = S_SRCH_EV;
            end
         end

         S_SRCH_EV: begin
            if (entry.code == code_ff) begin
               ram_wdata.count   = CNT_BITS'(1);
               ram_wdata.pending = 1'b1;
               if (raise_ff) begin
                  // Re-arm an inactive code.
                  ram_wdata.active = 1'b1;
                  ram_we           = !entry.active;
               end else begin
                  // Release an active code that was reported.
                  ram_wdata.active = 1'b0;
                  ram_we           = entry.active && entry.reported;
               end
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + TOT_W'(1);
               state_in = S_SRCH_RD;
            end
         end

         // Evict the oldest entry by moving every later entry down by one.
         S_SHIFT_RD: begin
            if (idx_ff >= total_ff) begin
               total_in = total_ff - TOT_W'(1);
               state_in = S_APPEND;
            end else begin
               ram_re   = 1'b1;
               state_in = S_SHIFT_EV;
            end
         end

         S_SHIFT_EV: begin
            ram_we    = 1'b1;
            ram_waddr = idx_dec[IDX_W-1:0];
            idx_in    = idx_ff + TOT_W'(1);
            state_in  = S_SHIFT_RD;
         end

         // Append the new code at the end of the table.
         S_APPEND: begin
            ram_we             = 1'b1;
            ram_waddr          = total_ff[IDX_W-1:0];
            ram_wdata.code     = code_ff;
            ram_wdata.active   = 1'b1;
            ram_wdata.count    = CNT_BITS'(1);
            ram_wdata.reported = 1'b0;
            ram_wdata.pending  = 1'b1;
            total_in           = total_ff + TOT_W'(1);
            state_in           = S_IDLE;
         end

         // Tick sweep: report, update and compact in one pass.
         S_TICK_RD: begin
            if (idx_ff == total_ff) begin
               state_in = S_TICK_END;
            end else begin
               ram_re   = 1'b1;
               state_in = S_TICK_EV;
            end
         end

         S_TICK_EV: begin
            if (entry.pending) begin
               // A held result can move out only when the output is free.
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     rsp_in       = hold_ff;
                     rsp_valid_in = 1'b1;
                  end
                  hold_in.report_code   = entry.code;
                  hold_in.report_active = entry.active;
                  hold_in.report_count  = entry.count[7:0];
                  hold_in.last          = 1'b0;
                  hold_valid_in         = 1'b1;
                  ram_we                = 1'b1;
                  ram_waddr             = wptr_ff[IDX_W-1:0];
                  ram_wdata.count       = count_inc;
                  ram_wdata.reported    = 1'b1;
                  ram_wdata.pending     = !(count_inc > repeat_ext);
                  wptr_in               = wptr_ff + TOT_W'(1);
                  idx_in                = idx_ff + TOT_W'(1);
                  state_in              = S_TICK_RD;
               end
            end else if (!entry.active && (entry.count > repeat_ext)) begin
               // Released and fully reported: drop it.
               idx_in   = idx_ff + TOT_W'(1);
               state_in = S_TICK_RD;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = wptr_ff[IDX_W-1:0];
               wptr_in   = wptr_ff + TOT_W'(1);
               idx_in    = idx_ff + TOT_W'(1);
               state_in  = S_TICK_RD;
            end
         end

         // The last held result goes out flagged as the final beat.
         S_TICK_END: begin
            if (!hold_valid_ff) begin
               total_in = wptr_ff;
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in        = hold_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               total_in      = wptr_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      raise_ff <= raise_in;
      code_ff  <= code_in;
      idx_ff   <= idx_in;
      wptr_ff  <= wptr_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   // Configuration registers.
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff <= REPEAT_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_REPEAT_COUNT: repeat_ff <= csr_pwdata[7:0];
            REG_TABLE_LIMIT:  limit_ff  <= csr_pwdata[4:0];
            default:          repeat_ff <= repeat_ff;
         endcase
      end
   end

   // Configuration read-back.
   always_comb begin
      unique case (csr_paddr[2])
         REG_REPEAT_COUNT: csr_prdata = {24'd0, repeat_ff};
         REG_TABLE_LIMIT:  csr_prdata = {27'd0, limit_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/eert_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module eert_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
